// ===== rtl/idld_pkg.sv =====
// ----------------------------------------------------------------------------
// idld_pkg
// shared types, codes and arithmetic helpers of the icon display-list decoder
// ----------------------------------------------------------------------------
package idld_pkg;

  // result kinds
  typedef enum logic [2:0] {
    K_LINE = 3'd0,
    K_CIRC = 3'd1,
    K_DISC = 3'd2,
    K_RECT = 3'd3,
    K_END  = 3'd4,
    K_ERR  = 3'd5
  } prim_kind_t;

  // display-list opcodes
  localparam logic signed [7:0] OP_END  = 8'sd0;
  localparam logic signed [7:0] OP_LINE = 8'sd1;
  localparam logic signed [7:0] OP_CIRC = 8'sd2;
  localparam logic signed [7:0] OP_DISC = 8'sd3;
  localparam logic signed [7:0] OP_RECT = 8'sd4;

  // configuration register indexes
  localparam logic [1:0] CFG_CENTER_X   = 2'd0;
  localparam logic [1:0] CFG_CENTER_Y   = 2'd1;
  localparam logic [1:0] CFG_GLYPH_SIZE = 2'd2;

  localparam int CFG_DATA_W = 10;
  localparam int CFG_INDEX_W = 2;

  // parser phases
  typedef enum logic [4:0] {
    PH_OPCODE = 5'b00001,
    PH_COUNT  = 5'b00010,
    PH_PX     = 5'b00100,
    PH_PY     = 5'b01000,
    PH_SHAPE  = 5'b10000
  } phase_t;

  // work handed from the parser to the result stage
  typedef struct packed {
    logic              valid;
    logic              emit;
    prim_kind_t        kind;
    logic signed [16:0] m0;
    logic signed [16:0] m1;
    logic signed [16:0] m2;
    logic signed [16:0] m3;
  } job_t;

  // signed byte times glyph size
  function automatic logic signed [16:0] mul_g(input logic signed [7:0] c,
                                               input logic [7:0] g);
    logic signed [16:0] a;
    logic signed [16:0] b;
    a = $signed({{9{c[7]}}, c});
    b = $signed({9'd0, g});
    return a * b;
  endfunction

  // floor(t / 7) for t below 8192, reciprocal multiply
  function automatic logic [10:0] div7(input logic [12:0] t);
    logic [26:0] pr;
    pr = 27'(t) * 27'(14'd9363);
    return pr[26:16];
  endfunction

  // p / 28, truncated toward zero
  function automatic logic signed [11:0] scale28(input logic signed [16:0] p);
    logic [16:0]        mag;
    logic signed [11:0] qs;
    mag = p[16] ? 17'(-p) : 17'(p);
    qs  = $signed({1'b0, div7(mag[14:2])});
    return p[16] ? -qs : qs;
  endfunction

  // p / 56, truncated toward zero
  function automatic logic signed [11:0] scale56(input logic signed [16:0] p);
    logic [16:0]        mag;
    logic signed [11:0] qs;
    mag = p[16] ? 17'(-p) : 17'(p);
    qs  = $signed({1'b0, div7({1'b0, mag[14:3]})});
    return p[16] ? -qs : qs;
  endfunction

  // saturate to the 11 bit signed range
  function automatic logic signed [10:0] sat11(input logic signed [12:0] v);
    logic signed [10:0] r;
    if (v > 13'sd1023) begin
      r = 11'sd1023;
    end else if (v < -13'sd1024) begin
      r = 11'sh400;
    end else begin
      r = v[10:0];
    end
    return r;
  endfunction

  // glyph size / 11, at least 2
  function automatic logic [4:0] stroke(input logic [7:0] g);
    logic [16:0] pr;
    logic [4:0]  w;
    pr = 17'(g) * 17'(9'd373);
    w  = pr[16:12];
    return (w < 5'd2) ? 5'd2 : w;
  endfunction

endpackage

// ===== rtl/idld_if.sv =====
// ----------------------------------------------------------------------------
// idld_if
// valid/ready channels for display-list words and primitive words
// ----------------------------------------------------------------------------
interface idld_code_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] code_byte;
  logic              start_of_symbol;

  modport source (output valid, output code_byte, output start_of_symbol, input ready);
  modport sink   (input valid, input code_byte, input start_of_symbol, output ready);
endinterface

interface idld_prim_if;
  logic               valid;
  logic               ready;
  logic [2:0]         prim_kind;
  logic signed [10:0] point_x;
  logic signed [10:0] point_y;
  logic signed [10:0] end_x;
  logic signed [10:0] end_y;
  logic [9:0]         radius;
  logic [4:0]         stroke_width;

  modport source (output valid, output prim_kind, output point_x, output point_y,
                  output end_x, output end_y, output radius, output stroke_width,
                  input ready);
  modport sink   (input valid, input prim_kind, input point_x, input point_y,
                  input end_x, input end_y, input radius, input stroke_width,
                  output ready);
endinterface

// ===== rtl/icon_display_list_decoder_top.sv =====
// ----------------------------------------------------------------------------
// icon_display_list_decoder_top
// icon display-list parser that turns signed table bytes into draw primitives
// ----------------------------------------------------------------------------
// One display-list byte is taken per cycle while ready is high; a primitive word
// comes from the byte that completes it: the byte is parsed and its operands
// multiplied by the glyph size into a job register, then the divide by 28 or 56,
// centre offset and saturation fill the result register. Ready drops only while
// both the job register and the result register hold words and the result is not
// taken. Polylines give one line word per segment, circles, filled circles and
// rectangles one word each, the end byte an end word; an unknown opcode or a
// negative count gives an error word, and after an end or error word bytes are
// dropped until a byte with start_of_symbol set. Configuration (center and glyph
// size) must be written by the user only while idle; the block does not enforce.
// ----------------------------------------------------------------------------
module icon_display_list_decoder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [idld_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [idld_pkg::CFG_DATA_W-1:0]   cfg_data,
  idld_code_if.sink                         code,
  idld_prim_if.source                       prim
);

  // configuration registers
  logic signed [9:0] center_x;
  logic signed [9:0] center_y;
  logic [7:0]        glyph_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= '0;
      center_y   <= '0;
      glyph_size <= 8'd24;
    end else if (cfg_we) begin
      // writes beyond the register list are dropped
      if (cfg_index == idld_pkg::CFG_CENTER_X) begin
        center_x <= cfg_data[9:0];
      end else if (cfg_index == idld_pkg::CFG_CENTER_Y) begin
        center_y <= cfg_data[9:0];
      end else if (cfg_index == idld_pkg::CFG_GLYPH_SIZE) begin
        glyph_size <= cfg_data[7:0];
      end
    end
  end

  // parser state
  idld_pkg::phase_t     phase;
  idld_pkg::prim_kind_t shape_kind;
  logic [6:0]           points_left;
  logic [7:0]           held [3];
  logic                 have_prev;
  logic                 halted;

  idld_pkg::phase_t     phase_next;
  idld_pkg::prim_kind_t shape_kind_next;
  logic [6:0]           points_left_next;
  logic [7:0]           held_next [3];
  logic                 have_prev_next;
  logic                 halted_next;

  // pipeline registers
  idld_pkg::job_t job;
  idld_pkg::job_t job_next;
  logic           out_valid;

  // handshake: result stage moves when its word is gone or being taken,
  // the job register when it is empty or moving on
  logic adv;
  logic job_en;
  logic accept;

  assign adv        = !out_valid || prim.ready;
  assign job_en     = !job.valid || adv;
  assign code.ready = job_en;
  assign accept     = code.valid && job_en;

  // ---------------------------------------------------------------------------
  // parser: next state and the job for the result stage
  // ---------------------------------------------------------------------------
  logic signed [7:0] b;
  logic              shape_done;
  logic [7:0]        y_byte;

  assign b = code.code_byte;

  always_comb begin
    phase_next       = phase;
    shape_kind_next  = shape_kind;
    points_left_next = points_left;
    held_next        = held;
    have_prev_next   = have_prev;
    halted_next      = halted;
    job_next.valid   = 1'b0;
    job_next.emit    = 1'b0;
    job_next.kind    = idld_pkg::K_END;
    shape_done       = 1'b0;
    y_byte           = held[1];

    // start flag restarts the parser, this byte is an opcode
    if (code.start_of_symbol) begin
      halted_next      = 1'b0;
      phase_next       = idld_pkg::PH_OPCODE;
      points_left_next = '0;
      have_prev_next   = 1'b0;
    end

    if (!halted_next) begin
      unique case (phase_next)
        idld_pkg::PH_OPCODE: begin
          if (b == idld_pkg::OP_END) begin
            halted_next    = 1'b1;
            job_next.valid = 1'b1;
            job_next.emit  = 1'b1;
            job_next.kind  = idld_pkg::K_END;
          end else if (b < idld_pkg::OP_LINE || b > idld_pkg::OP_RECT) begin
            halted_next    = 1'b1;
            job_next.valid = 1'b1;
            job_next.emit  = 1'b1;
            job_next.kind  = idld_pkg::K_ERR;
          end else begin
            points_left_next = '0;
            if (b == idld_pkg::OP_LINE) begin
              shape_kind_next = idld_pkg::K_LINE;
              phase_next      = idld_pkg::PH_COUNT;
            end else begin
              if (b == idld_pkg::OP_CIRC) begin
                shape_kind_next = idld_pkg::K_CIRC;
              end else if (b == idld_pkg::OP_DISC) begin
                shape_kind_next = idld_pkg::K_DISC;
              end else begin
                shape_kind_next = idld_pkg::K_RECT;
              end
              phase_next = idld_pkg::PH_SHAPE;
            end
          end
        end
        idld_pkg::PH_COUNT: begin
          if (b < 8'sd0) begin
            halted_next    = 1'b1;
            phase_next     = idld_pkg::PH_OPCODE;
            job_next.valid = 1'b1;
            job_next.emit  = 1'b1;
            job_next.kind  = idld_pkg::K_ERR;
          end else begin
            have_prev_next   = 1'b0;
            points_left_next = b[6:0];
            phase_next       = (b[6:0] != 7'd0) ? idld_pkg::PH_PX : idld_pkg::PH_OPCODE;
          end
        end
        idld_pkg::PH_PX: begin
          held_next[0] = b;
          phase_next   = idld_pkg::PH_PY;
        end
        idld_pkg::PH_PY: begin
          // every point updates the previous point, a segment needs two
          y_byte           = b;
          job_next.valid   = 1'b1;
          job_next.emit    = have_prev_next;
          job_next.kind    = idld_pkg::K_LINE;
          have_prev_next   = 1'b1;
          points_left_next = points_left_next - 7'd1;
          phase_next       = (points_left_next != 7'd0) ? idld_pkg::PH_PX
                                                        : idld_pkg::PH_OPCODE;
        end
        idld_pkg::PH_SHAPE: begin
          // circles end on their third operand, rectangles on their fourth
          if (points_left_next >= 7'd3 ||
              (shape_kind != idld_pkg::K_RECT && points_left_next == 7'd2)) begin
            shape_done = 1'b1;
          end else begin
            held_next[points_left_next[1:0]] = b;
            points_left_next = points_left_next + 7'd1;
          end
          if (shape_done) begin
            job_next.valid   = 1'b1;
            job_next.emit    = 1'b1;
            job_next.kind    = shape_kind;
            phase_next       = idld_pkg::PH_OPCODE;
            points_left_next = '0;
          end
        end
        default: begin
          phase_next = idld_pkg::PH_OPCODE;
        end
      endcase
    end

    // operand products: x, y, rect width and the last byte
    job_next.m0 = idld_pkg::mul_g(held[0], glyph_size);
    job_next.m1 = idld_pkg::mul_g(y_byte, glyph_size);
    job_next.m2 = idld_pkg::mul_g(held[2], glyph_size);
    job_next.m3 = idld_pkg::mul_g(b, glyph_size);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= idld_pkg::PH_OPCODE;
      shape_kind  <= idld_pkg::K_LINE;
      points_left <= '0;
      have_prev   <= 1'b0;
      halted      <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      shape_kind  <= shape_kind_next;
      points_left <= points_left_next;
      have_prev   <= have_prev_next;
      halted      <= halted_next;
    end
  end

  // operand bytes, always written before read
  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job.valid <= 1'b0;
    end else if (job_en) begin
      job.valid <= accept && job_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_en) begin
      job.emit <= job_next.emit;
      job.kind <= job_next.kind;
      job.m0   <= job_next.m0;
      job.m1   <= job_next.m1;
      job.m2   <= job_next.m2;
      job.m3   <= job_next.m3;
    end
  end

  // ---------------------------------------------------------------------------
  // result stage: divide, offset, saturate
  // ---------------------------------------------------------------------------
  logic signed [10:0] prev_x;
  logic signed [10:0] prev_y;
  logic signed [10:0] new_x;
  logic signed [10:0] new_y;
  logic signed [11:0] sc_w;
  logic signed [11:0] sc_h;
  logic signed [11:0] sc_r;
  logic signed [12:0] r_sum;
  logic [9:0]         r_clamped;
  logic [4:0]         stroke_w;

  logic [2:0]         kind_next;
  logic signed [10:0] point_x_next;
  logic signed [10:0] point_y_next;
  logic signed [10:0] end_x_next;
  logic signed [10:0] end_y_next;
  logic [9:0]         radius_next;

  logic [2:0]         out_kind;
  logic signed [10:0] out_point_x;
  logic signed [10:0] out_point_y;
  logic signed [10:0] out_end_x;
  logic signed [10:0] out_end_y;
  logic [9:0]         out_radius;
  logic [4:0]         out_stroke;

  always_comb begin
    stroke_w = idld_pkg::stroke(glyph_size);
    new_x = idld_pkg::sat11($signed({{3{center_x[9]}}, center_x})
                            + 13'(idld_pkg::scale28(job.m0)));
    new_y = idld_pkg::sat11($signed({{3{center_y[9]}}, center_y})
                            + 13'(idld_pkg::scale28(job.m1)));
    sc_w  = idld_pkg::scale28(job.m2);
    sc_h  = idld_pkg::scale28(job.m3);
    sc_r  = idld_pkg::scale56(job.m3);

    // filled circles widen by a quarter stroke, then clamp to 0..1023
    r_sum = 13'(sc_r);
    if (job.kind == idld_pkg::K_DISC) begin
      r_sum = r_sum + $signed({8'd0, stroke_w[4:2]});
    end
    if (r_sum < 13'sd0) begin
      r_clamped = '0;
    end else if (r_sum > 13'sd1023) begin
      r_clamped = 10'd1023;
    end else begin
      r_clamped = r_sum[9:0];
    end

    kind_next    = job.kind;
    point_x_next = '0;
    point_y_next = '0;
    end_x_next   = '0;
    end_y_next   = '0;
    radius_next  = '0;
    unique case (job.kind)
      idld_pkg::K_LINE: begin
        point_x_next = prev_x;
        point_y_next = prev_y;
        end_x_next   = new_x;
        end_y_next   = new_y;
      end
      idld_pkg::K_CIRC, idld_pkg::K_DISC: begin
        point_x_next = new_x;
        point_y_next = new_y;
        radius_next  = r_clamped;
      end
      idld_pkg::K_RECT: begin
        point_x_next = new_x;
        point_y_next = new_y;
        end_x_next   = idld_pkg::sat11(13'(sc_w) + 13'sd1);
        end_y_next   = idld_pkg::sat11(13'(sc_h) + 13'sd1);
      end
      idld_pkg::K_END, idld_pkg::K_ERR: begin
        // all geometry fields stay zero
      end
      default: begin
        kind_next = idld_pkg::K_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
    end else if (adv) begin
      out_valid <= job.valid && job.emit;
      if (job.valid && job.kind == idld_pkg::K_LINE) begin
        prev_x <= new_x;
        prev_y <= new_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && job.valid) begin
      out_kind    <= kind_next;
      out_point_x <= point_x_next;
      out_point_y <= point_y_next;
      out_end_x   <= end_x_next;
      out_end_y   <= end_y_next;
      out_radius  <= radius_next;
      out_stroke  <= stroke_w;
    end
  end

  assign prim.valid        = out_valid;
  assign prim.prim_kind    = out_kind;
  assign prim.point_x      = out_point_x;
  assign prim.point_y      = out_point_y;
  assign prim.end_x        = out_end_x;
  assign prim.end_y        = out_end_y;
  assign prim.radius       = out_radius;
  assign prim.stroke_width = out_stroke;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the icon display-list decoder: display-list words
// go in through a bursty sender, primitive words come out against a stalling
// receiver, and each one is compared with a cycle-free decoder kept here
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import idld_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;     // parser plus result stage, with margin
  localparam int DRAIN_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 800;
  localparam int SEGMENTS      = 8;

  // one expected primitive word
  typedef struct {
    prim_kind_t         kind;
    logic signed [10:0] px;
    logic signed [10:0] py;
    logic signed [10:0] ex;
    logic signed [10:0] ey;
    logic [9:0]         radius;
    logic [4:0]         stroke;
  } prim_word_t;

  // receiver back-pressure styles
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  idld_code_if code_ch ();
  idld_prim_if prim_ch ();

  icon_display_list_decoder_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .code      (code_ch),
    .prim      (prim_ch)
  );

  // --------------------------------------------------------------------------
  // decoder state mirrored by the bench
  // --------------------------------------------------------------------------
  logic signed [9:0] ctr_x;
  logic signed [9:0] ctr_y;
  logic [7:0]        glyph;
  phase_t            phase;
  logic signed [7:0] op_held;
  int unsigned       pts_left;
  logic signed [7:0] operand [3];
  int                last_x;
  int                last_y;
  bit                have_last;
  bit                halted;

  prim_word_t  pending_prims [$];   // primitive words still owed by the block
  int          mismatch_count;
  int          fed_items;           // display-list words that were not dropped
  int unsigned cycle_count;

  // sender pacing: words go out in bursts, gap_max of zero means back to back
  int burst_left;
  int gap_max;

  // receiver pacing
  rx_mode_t rx_mode;
  int       rx_left;
  int       rx_tick;

  // --------------------------------------------------------------------------
  // arithmetic of the decoder
  // --------------------------------------------------------------------------
  function automatic int clip11(input int v);
    if (v > 1023) begin
      return 1023;
    end else if (v < -1024) begin
      return -1024;
    end
    return v;
  endfunction

  // byte times glyph size over 28, truncated toward zero
  function automatic int scale_byte(input logic signed [7:0] c);
    return int'(c) * int'(glyph) / 28;
  endfunction

  function automatic int place(input logic signed [7:0] c, input logic signed [9:0] ctr);
    return clip11(int'(ctr) + scale_byte(c));
  endfunction

  function automatic logic [4:0] line_width();
    int w;
    w = int'(glyph) / 11;
    if (w < 2) begin
      w = 2;
    end
    return w[4:0];
  endfunction

  function automatic void push_word(input prim_kind_t kind, input int px, input int py,
                                    input int ex, input int ey, input int r);
    prim_word_t w;
    w.kind   = kind;
    w.px     = px[10:0];
    w.py     = py[10:0];
    w.ex     = ex[10:0];
    w.ey     = ey[10:0];
    w.radius = r[9:0];
    w.stroke = line_width();
    pending_prims.push_back(w);
  endfunction

  function automatic void reset_decoder();
    ctr_x     = '0;
    ctr_y     = '0;
    glyph     = 8'd24;
    phase     = PH_OPCODE;
    op_held   = OP_END;
    pts_left  = 0;
    operand   = '{default: '0};
    last_x    = 0;
    last_y    = 0;
    have_last = 1'b0;
    halted    = 1'b0;
  endfunction

  // parse one display-list word; returns 0 when the word is dropped while halted
  function automatic bit decode_byte(input logic signed [7:0] b, input logic sos);
    int px;
    int py;
    int r;
    bit had;
    if (sos) begin
      halted    = 1'b0;
      phase     = PH_OPCODE;
      pts_left  = 0;
      have_last = 1'b0;
    end
    if (halted) begin
      return 1'b0;
    end
    case (phase)
      PH_OPCODE: begin
        if (b == OP_END) begin
          halted = 1'b1;
          push_word(K_END, 0, 0, 0, 0, 0);
        end else if (b < OP_LINE || b > OP_RECT) begin
          halted = 1'b1;
          push_word(K_ERR, 0, 0, 0, 0, 0);
        end else begin
          op_held  = b;
          pts_left = 0;
          if (b == OP_LINE) begin
            phase = PH_COUNT;
          end else begin
            phase = PH_SHAPE;
          end
        end
      end
      PH_COUNT: begin
        if (b < 0) begin
          halted = 1'b1;
          phase  = PH_OPCODE;
          push_word(K_ERR, 0, 0, 0, 0, 0);
        end else begin
          have_last = 1'b0;
          pts_left  = int'(b) & 127;
          if (pts_left != 0) begin
            phase = PH_PX;
          end else begin
            phase = PH_OPCODE;
          end
        end
      end
      PH_PX: begin
        operand[0] = b;
        phase      = PH_PY;
      end
      PH_PY: begin
        had = have_last;
        px  = place(operand[0], ctr_x);
        py  = place(b, ctr_y);
        if (had) begin
          push_word(K_LINE, last_x, last_y, px, py, 0);
        end
        last_x    = px;
        last_y    = py;
        have_last = 1'b1;
        pts_left  = (pts_left - 1) & 127;
        if (pts_left != 0) begin
          phase = PH_PX;
        end else begin
          phase = PH_OPCODE;
        end
      end
      PH_SHAPE: begin
        // circles hold x, y and close on r; rectangles hold x, y, w and close on h
        if (pts_left < 3 && !(op_held != OP_RECT && pts_left == 2)) begin
          operand[pts_left] = b;
          pts_left++;
        end else begin
          px       = place(operand[0], ctr_x);
          py       = place(operand[1], ctr_y);
          phase    = PH_OPCODE;
          pts_left = 0;
          if (op_held == OP_RECT) begin
            push_word(K_RECT, px, py, clip11(scale_byte(operand[2]) + 1),
                      clip11(scale_byte(b) + 1), 0);
          end else begin
            r = int'(b) * int'(glyph) / 56;
            if (op_held == OP_DISC) begin
              r += int'(line_width()) / 4;
            end
            if (r < 0) begin
              r = 0;
            end
            if (r > 1023) begin
              r = 1023;
            end
            if (op_held == OP_DISC) begin
              push_word(K_DISC, px, py, 0, 0, r);
            end else begin
              push_word(K_CIRC, px, py, 0, 0, r);
            end
          end
        end
      end
      default: begin
        phase = PH_OPCODE;
      end
    endcase
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // reporting and checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [10:0] got,
                             input logic [10:0] want, input prim_kind_t kind);
    if (got !== want) begin
      report_mismatch($sformatf("%s of %s word: got %0h, expected %0h",
                                name, kind.name(), got, want));
    end
  endtask

  // compare the primitive word accepted at this edge with the oldest expectation
  task automatic check_word();
    prim_word_t want;
    if (pending_prims.size() == 0) begin
      report_mismatch($sformatf("primitive word of kind %0d with nothing expected",
                                prim_ch.prim_kind));
      return;
    end
    want = pending_prims.pop_front();
    check_field("prim_kind", 11'(prim_ch.prim_kind), 11'(want.kind), want.kind);
    check_field("point_x", prim_ch.point_x, want.px, want.kind);
    check_field("point_y", prim_ch.point_y, want.py, want.kind);
    check_field("end_x", prim_ch.end_x, want.ex, want.kind);
    check_field("end_y", prim_ch.end_y, want.ey, want.kind);
    check_field("radius", 11'(prim_ch.radius), 11'(want.radius), want.kind);
    check_field("stroke_width", 11'(prim_ch.stroke_width), 11'(want.stroke), want.kind);
  endtask

  // --------------------------------------------------------------------------
  // clock, watchdog, receiver
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] watchdog expired with %0d words outstanding",
               $realtime, pending_prims.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // values read here are the ones seen at the edge; ready for the next edge
  // goes out by nonblocking assignment in the same pass
  always @(posedge clk) begin
    if (!rst && prim_ch.valid && prim_ch.ready) begin
      check_word();
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     prim_ch.ready <= 1'b1;
      RX_RANDOM:   prim_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: prim_ch.ready <= (rx_tick % 7 < 3);
      default:     prim_ch.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // offer one display-list word and hold it until the block takes it; valid is
  // left high so the next word can follow on the very next edge
  task automatic send_word(input logic signed [7:0] b, input logic sos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        code_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    code_ch.valid           <= 1'b1;
    code_ch.code_byte       <= b;
    code_ch.start_of_symbol <= sos;
    @(posedge clk);
    while (!code_ch.ready) begin
      @(posedge clk);
    end
    if (decode_byte(b, sos)) begin
      fed_items++;
    end
  endtask

  // stop sending and let every owed primitive word come out, then let the
  // pipeline settle in case the last word produced nothing
  task automatic wait_idle();
    code_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_prims.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers on back-to-back edges; only called when idle
  task automatic set_config(input logic signed [9:0] cx, input logic signed [9:0] cy,
                            input logic [7:0] g);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CENTER_X;
    cfg_data  <= cx;
    @(posedge clk);
    cfg_index <= CFG_CENTER_Y;
    cfg_data  <= cy;
    @(posedge clk);
    cfg_index <= CFG_GLYPH_SIZE;
    cfg_data  <= {2'b00, g};
    @(posedge clk);
    cfg_we <= 1'b0;
    ctr_x = cx;
    ctr_y = cy;
    glyph = g;
  endtask

  function automatic logic signed [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // one display-list command, mostly well formed with random operands
  task automatic send_random_command();
    int   pick;
    int   n;
    int   i;
    int   bad;
    logic sos;
    // restart the parser most of the time when it is halted or mid-command
    if (halted || phase != PH_OPCODE) begin
      sos = ($urandom_range(0, 9) != 0);
    end else begin
      sos = ($urandom_range(0, 9) == 0);
    end
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      // polyline, now and then with a long point list
      n = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
      send_word(OP_LINE, sos);
      send_word(8'(n), 1'b0);
      for (i = 0; i < n; i++) begin
        send_word(rand_byte(), 1'b0);
        send_word(rand_byte(), 1'b0);
      end
    end else if (pick < 46) begin
      send_word(($urandom_range(0, 1) != 0) ? OP_CIRC : OP_DISC, sos);
      repeat (3) send_word(rand_byte(), 1'b0);
    end else if (pick < 66) begin
      send_word(OP_RECT, sos);
      repeat (4) send_word(rand_byte(), 1'b0);
    end else if (pick < 72) begin
      send_word(OP_END, sos);
    end else if (pick < 78) begin
      // opcode outside the table, either side
      if ($urandom_range(0, 1) != 0) begin
        bad = $urandom_range(5, 127);
      end else begin
        bad = -int'($urandom_range(1, 128));
      end
      send_word(8'(bad), sos);
    end else if (pick < 82) begin
      send_word(OP_LINE, sos);
      send_word(8'(-int'($urandom_range(1, 128))), 1'b0);
    end else if (pick < 92) begin
      // noise
      repeat ($urandom_range(1, 4)) send_word(rand_byte(), $urandom_range(0, 7) == 0);
    end else begin
      // command cut short, the next one mostly restarts over it
      send_word(8'($urandom_range(1, 4)), sos);
      repeat ($urandom_range(0, 2)) send_word(rand_byte(), 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // largest glyph with the center at a corner: coordinates pushed past the range saturate
  task automatic test_extreme_scaling();
    set_config(511, -512, 255);
    gap_max = 0;
    // rectangle with all four operands at the byte limits
    send_word(OP_RECT, 1'b1);
    send_word(127, 1'b0);
    send_word(-128, 1'b0);
    send_word(127, 1'b0);
    send_word(-128, 1'b0);
    // filled circle with a radius that stays negative after the fill term
    send_word(OP_DISC, 1'b0);
    send_word(0, 1'b0);
    send_word(0, 1'b0);
    send_word(-128, 1'b0);
    // one segment between opposite extremes
    send_word(OP_LINE, 1'b0);
    send_word(2, 1'b0);
    send_word(127, 1'b0);
    send_word(127, 1'b0);
    send_word(-128, 1'b0);
    send_word(-128, 1'b0);
    // end word, then a word that must be dropped
    send_word(OP_END, 1'b0);
    send_word(7, 1'b0);
    wait_idle();
  endtask

  // counts of zero and one, errors, and restarts of the parser
  task automatic test_parser_special_cases();
    set_config(-100, 45, 24);
    gap_max = 3;
    send_word(OP_LINE, 1'b1);
    send_word(0, 1'b0);           // zero count goes straight back to opcodes
    send_word(OP_CIRC, 1'b0);
    send_word(10, 1'b0);
    send_word(-10, 1'b0);
    send_word(127, 1'b0);
    send_word(OP_LINE, 1'b1);
    send_word(1, 1'b0);           // single point, no segment
    send_word(3, 1'b0);
    send_word(3, 1'b0);
    send_word(5, 1'b0);           // first opcode past the table
    send_word(OP_CIRC, 1'b0);     // dropped while halted
    send_word(-128, 1'b1);        // negative opcode
    send_word(OP_LINE, 1'b1);
    send_word(-1, 1'b0);          // negative count
    send_word(OP_RECT, 1'b1);
    send_word(5, 1'b0);
    send_word(OP_END, 1'b1);      // start flag in the middle of a rectangle
    wait_idle();
  endtask

  // random commands over several register settings and pacing styles
  task automatic test_random_stream();
    int seg;
    int target;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      case (seg)
        0:       set_config(0, 0, 24);
        1:       set_config(511, 511, 255);
        2:       set_config(-512, -512, 0);
        3:       set_config(-512, 511, 1);
        4:       set_config(511, -512, 254);
        default: set_config(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                            8'($urandom_range(0, 255)));
      endcase
      // every third segment runs without sender gaps
      gap_max = (seg % 3 == 0) ? 0 : $urandom_range(1, 8);
      target  = fed_items + RANDOM_ITEMS / SEGMENTS;
      while (fed_items < target) begin
        send_random_command();
        // now and then the sender holds off until the block has delivered everything
        if ($urandom_range(0, 39) == 0) begin
          wait_idle();
        end
      end
    end
  endtask

  // let the last words out; whatever is still owed after that is a failure
  task automatic drain_results();
    int waited;
    code_ch.valid <= 1'b0;
    waited = 0;
    while (pending_prims.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (pending_prims.size() != 0) begin
      report_mismatch($sformatf("%0d primitive words never arrived", pending_prims.size()));
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_index               <= CFG_CENTER_X;
    cfg_data                <= '0;
    code_ch.valid           <= 1'b0;
    code_ch.code_byte       <= '0;
    code_ch.start_of_symbol <= 1'b0;
    reset_decoder();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extreme_scaling();
    test_parser_special_cases();
    test_random_stream();
    drain_results();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
